>>> design/b48id_pkg.sv
// ----------------------------------------------------------------------------
// b48id_pkg
// Shared widths, character constants, alphabet table and digit helpers for
// the base-48 identifier codec.
// ----------------------------------------------------------------------------
package b48id_pkg;

  localparam int NUM_W      = 48;
  localparam int TEXT_W     = 40;
  localparam int CHAR_W     = 8;
  localparam int CHARS_WORD = TEXT_W / CHAR_W;
  localparam int N_CHARS    = 2 * CHARS_WORD;
  localparam int DIG_W      = 6;
  localparam int N_DIG      = 9;
  localparam int RADIX      = 48;
  localparam int ACC_W      = 51;
  localparam int DAB_W      = NUM_W + N_DIG * DIG_W;
  localparam int DAB_STAGES = 8;
  localparam int DAB_ITERS  = NUM_W / DAB_STAGES;
  localparam int DEC_STAGES = DAB_STAGES;

  localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;

  // a digit at or above half the radix overflows when doubled
  localparam logic [DIG_W-1:0] DIG_HALF = 6'd24;
  localparam logic [DIG_W-1:0] DIG_ADJ  = 6'd8;
  localparam logic [DIG_W-1:0] DIG_TOP_MAX = 6'd9;

  // symbol 0 in the top byte
  localparam logic [RADIX*CHAR_W-1:0] ALPHABET =
      "0123456789abcdefhijkmnpqrstuvwxyzABCDEFHIJKLMPRU";

  // weight of digit m, digit 0 being the leading decimal digit
  localparam logic [ACC_W-1:0] DIG_WEIGHT [N_DIG] = '{
    51'd28179280429056, 51'd587068342272, 51'd12230590464,
    51'd254803968,      51'd5308416,      51'd110592,
    51'd2304,           51'd48,           51'd1
  };

  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_DECODE = 1'b1
  } action_t;

  typedef struct packed {
    logic             ok;
    logic [DIG_W-1:0] val;
  } digit_t;

  typedef struct packed {
    logic [NUM_W-1:0] value;
    logic             invalid;
  } dec_res_t;

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (d < DIG_W'(RADIX)) begin
      c = ALPHABET[CHAR_W*(RADIX-1-int'(d)) +: CHAR_W];
    end
    return c;
  endfunction

  // alphabet has no NUL, so a zero byte never matches
  function automatic digit_t digit_lookup(input logic [CHAR_W-1:0] c);
    digit_t r;
    int     k;
    r = '0;
    for (k = 0; k < RADIX; k++) begin
      if (c == ALPHABET[CHAR_W*(RADIX-1-k) +: CHAR_W]) begin
        r.ok  = 1'b1;
        r.val = DIG_W'(k);
      end
    end
    return r;
  endfunction

  // one shift-and-adjust step: digits in the top field, binary bits below
  function automatic logic [DAB_W-1:0] dabble_step(input logic [DAB_W-1:0] s);
    logic [DAB_W-1:0] t;
    int               j;
    t = s;
    for (j = 0; j < N_DIG; j++) begin
      if (t[NUM_W+DIG_W*j +: DIG_W] >= DIG_HALF) begin
        t[NUM_W+DIG_W*j +: DIG_W] = t[NUM_W+DIG_W*j +: DIG_W] + DIG_ADJ;
      end
    end
    return {t[DAB_W-2:0], 1'b0};
  endfunction

  function automatic logic [DAB_W-1:0] dabble_stage(input logic [DAB_W-1:0] s);
    logic [DAB_W-1:0] t;
    int               i;
    t = s;
    for (i = 0; i < DAB_ITERS; i++) begin
      t = dabble_step(t);
    end
    return t;
  endfunction

endpackage

>>> design/base48_id_codec_unit.sv
// ----------------------------------------------------------------------------
// base48_id_codec_unit
// 48-bit number <-> 10-character identifier ('_', decimal digit, eight
// base-48 symbols), one word per cycle in either direction unless out_stall holds the pipeline.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_stall  | in_action, in_number, in_text_high/low
//  out     | out_valid/out_stall| out_value_out, out_chars_high/low, out_invalid
//
//  Input stage, eight conversion stages, output stage; one word accepted per cycle unless stalled.
//  The depth is set by the binary-to-base-48 shift-and-adjust conversion:
//  48 steps, six per stage over eight stages. Decode runs alongside.
//  Reset clears the stage valid bits only; no clearing pass.
//  Each stage moves on when it is empty or the next stage moves, so bubbles
//  fill while a finished word waits on out_stall.
// ----------------------------------------------------------------------------
module base48_id_codec_unit
  import b48id_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [NUM_W-1:0]  in_number,
  input  logic [TEXT_W-1:0] in_text_high,
  input  logic [TEXT_W-1:0] in_text_low,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NUM_W-1:0]  out_value_out,
  output logic [TEXT_W-1:0] out_chars_high,
  output logic [TEXT_W-1:0] out_chars_low,
  output logic              out_invalid
);

  localparam int OUT_STG = DAB_STAGES + 1;

  logic [OUT_STG+1:0] en;
  logic [OUT_STG:0]   v_r;
  logic [OUT_STG:0]   v_nxt;
  action_t            act_r   [0:DAB_STAGES];
  logic [DAB_W-1:0]   dab_r   [0:DAB_STAGES];
  logic [DAB_W-1:0]   dab_nxt [0:DAB_STAGES];
  logic [TEXT_W-1:0]  text_high_r;
  logic [TEXT_W-1:0]  text_low_r;
  dec_res_t           dec_res;

  logic [NUM_W-1:0]   value_r,  value_nxt;
  logic [TEXT_W-1:0]  chars_high_r, chars_high_nxt;
  logic [TEXT_W-1:0]  chars_low_r,  chars_low_nxt;
  logic               invalid_r, invalid_nxt;

  // stage k loads when empty or when stage k+1 loads
  always_comb begin
    en[OUT_STG+1] = !out_stall;
    for (int k = OUT_STG; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    v_nxt = v_r;
    if (en[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int k = 1; k <= OUT_STG; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_comb begin
    dab_nxt[0] = {{(N_DIG*DIG_W){1'b0}}, in_number};
    for (int k = 1; k <= DAB_STAGES; k++) begin
      dab_nxt[k] = dabble_stage(dab_r[k-1]);
    end
  end

  // output stage: pick the encode or decode side
  always_comb begin
    logic [DIG_W-1:0] d;
    d              = '0;
    value_nxt      = '0;
    invalid_nxt    = 1'b0;
    chars_high_nxt = '0;
    chars_low_nxt  = '0;
    if (act_r[DAB_STAGES] == ACT_DECODE) begin
      value_nxt   = dec_res.value;
      invalid_nxt = dec_res.invalid;
    end else begin
      d = dab_r[DAB_STAGES][DAB_W-1 -: DIG_W];
      chars_high_nxt[TEXT_W-1 -: CHAR_W]          = CHAR_UNDERSCORE;
      chars_high_nxt[TEXT_W-CHAR_W-1 -: CHAR_W]   = CHAR_ZERO + {4'h0, d[3:0]};
      // symbols 2..4 in the high word, 5..9 in the low word
      for (int m = 0; m < N_DIG - 1; m++) begin
        d = dab_r[DAB_STAGES][NUM_W+DIG_W*(N_DIG-2-m) +: DIG_W];
        if (m < CHARS_WORD - 2) begin
          chars_high_nxt[CHAR_W*(CHARS_WORD-3-m) +: CHAR_W] = alpha_char(d);
        end else begin
          chars_low_nxt[CHAR_W*(N_CHARS-3-m) +: CHAR_W] = alpha_char(d);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      act_r[0]    <= action_t'(in_action);
      dab_r[0]    <= dab_nxt[0];
      text_high_r <= in_text_high;
      text_low_r  <= in_text_low;
    end
    for (int k = 1; k <= DAB_STAGES; k++) begin
      if (en[k]) begin
        act_r[k] <= act_r[k-1];
        dab_r[k] <= dab_nxt[k];
      end
    end
    if (en[OUT_STG]) begin
      value_r      <= value_nxt;
      invalid_r    <= invalid_nxt;
      chars_high_r <= chars_high_nxt;
      chars_low_r  <= chars_low_nxt;
    end
  end

  b48id_decode u_decode (
    .clk       (clk),
    .stage_en  (en[DEC_STAGES:1]),
    .text_high (text_high_r),
    .text_low  (text_low_r),
    .res       (dec_res)
  );

  assign out_valid      = v_r[OUT_STG];
  assign out_value_out  = value_r;
  assign out_chars_high = chars_high_r;
  assign out_chars_low  = chars_low_r;
  assign out_invalid    = invalid_r;

`ifndef SYNTHESIS
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted word not captured in input stage");

  a_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DAB_STAGES] && (act_r[DAB_STAGES] == ACT_ENCODE)
      |-> dab_r[DAB_STAGES][DAB_W-1 -: DIG_W] <= DIG_TOP_MAX)
    else $error("leading decimal digit out of range");

  a_encode_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_chars_high != '0)
      |-> (out_chars_high[TEXT_W-1 -: CHAR_W] == CHAR_UNDERSCORE)
          && (out_value_out == '0) && !out_invalid)
    else $error("encode result malformed");

  a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid
      |-> (out_value_out == '0) && (out_chars_high == '0) && (out_chars_low == '0))
    else $error("invalid decode carries data");
`endif

endmodule

>>> design/b48id_decode.sv
// ----------------------------------------------------------------------------
// b48id_decode
// Pipelined text-to-number path: symbol lookup, weighted digit sums in an
// adder tree, range check, then delay to line up with the encode stages.
// ----------------------------------------------------------------------------
module b48id_decode
  import b48id_pkg::*;
(
  input  logic                  clk,
  input  logic [DEC_STAGES-1:0] stage_en,
  input  logic [TEXT_W-1:0]     text_high,
  input  logic [TEXT_W-1:0]     text_low,
  output dec_res_t              res
);

  logic [DIG_W-1:0] dig_r   [N_DIG];
  logic [DIG_W-1:0] dig_nxt [N_DIG];
  logic             ok_r    [1:4];
  logic             ok1_nxt;
  logic [ACC_W-1:0] p2_r    [5];
  logic [ACC_W-1:0] p2_nxt  [5];
  logic [ACC_W-1:0] p3_r    [3];
  logic [ACC_W-1:0] p4_r    [2];
  logic [ACC_W-1:0] acc;
  dec_res_t         res5_nxt;
  dec_res_t         res_r   [5:DEC_STAGES];

  // stage 1: character checks and digit values
  always_comb begin
    logic [CHAR_W-1:0] ch [N_CHARS];
    digit_t            dl;
    int                i;
    for (i = 0; i < N_CHARS; i++) begin
      if (i < CHARS_WORD) begin
        ch[i] = text_high[CHAR_W*(CHARS_WORD-1-i) +: CHAR_W];
      end else begin
        ch[i] = text_low[CHAR_W*(N_CHARS-1-i) +: CHAR_W];
      end
    end
    ok1_nxt    = (ch[0] == CHAR_UNDERSCORE) && (ch[1] >= CHAR_ZERO) && (ch[1] <= CHAR_NINE);
    dig_nxt[0] = {2'b00, ch[1][3:0]};
    for (i = 1; i < N_DIG; i++) begin
      dl         = digit_lookup(ch[i+1]);
      ok1_nxt    = ok1_nxt & dl.ok;
      dig_nxt[i] = dl.val;
    end
  end

  // stage 2: weighted digits, summed in pairs
  always_comb begin
    int j;
    for (j = 0; j < 4; j++) begin
      p2_nxt[j] = ACC_W'(dig_r[2*j]) * DIG_WEIGHT[2*j]
                + ACC_W'(dig_r[2*j+1]) * DIG_WEIGHT[2*j+1];
    end
    p2_nxt[4] = ACC_W'(dig_r[N_DIG-1]) * DIG_WEIGHT[N_DIG-1];
  end

  // stage 5: final sum and range check
  always_comb begin
    acc = p4_r[0] + p4_r[1];
    if (ok_r[4] && (acc[ACC_W-1:NUM_W] == '0)) begin
      res5_nxt.value   = acc[NUM_W-1:0];
      res5_nxt.invalid = 1'b0;
    end else begin
      res5_nxt.value   = '0;
      res5_nxt.invalid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      dig_r   <= dig_nxt;
      ok_r[1] <= ok1_nxt;
    end
    if (stage_en[1]) begin
      p2_r    <= p2_nxt;
      ok_r[2] <= ok_r[1];
    end
    if (stage_en[2]) begin
      p3_r[0] <= p2_r[0] + p2_r[1];
      p3_r[1] <= p2_r[2] + p2_r[3];
      p3_r[2] <= p2_r[4];
      ok_r[3] <= ok_r[2];
    end
    if (stage_en[3]) begin
      p4_r[0] <= p3_r[0] + p3_r[1];
      p4_r[1] <= p3_r[2];
      ok_r[4] <= ok_r[3];
    end
    if (stage_en[4]) begin
      res_r[5] <= res5_nxt;
    end
    for (int k = 6; k <= DEC_STAGES; k++) begin
      if (stage_en[k-1]) begin
        res_r[k] <= res_r[k-1];
      end
    end
  end

  assign res = res_r[DEC_STAGES];

endmodule
